>>> design/led_bs_pkg.sv
// Package for the LED blink sequencer: command codes, state and result types,
// timer width constants. Used by the core, buffer and top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package led_bs_pkg;

  // Elapsed timer width and the widths derived from it
  localparam int TIME_BITS = 16;
  localparam int CMP_W     = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [7:0]  FULL_LEVEL = 8'd255;
  localparam logic [15:0] CNT16_MAX  = 16'hFFFF;

  // Command codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ON       = 3'd1,
    OP_OFF      = 3'd2,
    OP_LEVEL    = 3'd3,
    OP_BLINK_N  = 3'd4,
    OP_BLINK_MS = 3'd5,
    OP_BLINK    = 3'd6,
    OP_STOP     = 3'd7
  } op_t;

  typedef struct packed {
    logic [7:0]           cur_level;
    logic                 lit;
    logic                 active;
    logic                 endless_mode;
    logic                 timed_mode;
    logic [15:0]          target_blinks;
    logic [15:0]          period_ms;
    logic [15:0]          total_ms;
    logic [TIME_BITS-1:0] since_toggle;
    logic [TIME_BITS-1:0] since_start;
    logic [15:0]          blinks_done;
  } state_t;

  typedef struct packed {
    logic       blink_ended;
    logic       state_changed;
    logic       is_blinking;
    logic       led_lit;
    logic [7:0] led_level;
  } result_t;

endpackage

`default_nettype wire

>>> design/led_bs_core.sv
// Next-state and result logic for one command or tick beat.
// Depends on led_bs_pkg for the state, result and command types.
`timescale 1ns / 1ps
`default_nettype none

module led_bs_core (
  input  led_bs_pkg::state_t  cur,
  input  led_bs_pkg::op_t     opcode,
  input  logic [7:0]          level,
  input  logic [15:0]         times,
  input  logic [15:0]         interval,
  input  logic [15:0]         duration,
  output led_bs_pkg::state_t  nxt,
  output led_bs_pkg::result_t res
);
  import led_bs_pkg::*;

  // Work out the state after this beat and the flags it raises
  always_comb begin
    logic [TIME_BITS-1:0] st_inc;
    logic [TIME_BITS-1:0] ss_inc;
    logic                 counting;
    logic                 changed;
    logic                 halt;

    nxt      = cur;
    changed  = 1'b0;
    halt     = 1'b0;
    counting = ~cur.endless_mode & ~cur.timed_mode;
    st_inc   = (cur.since_toggle == TIME_MAX) ? cur.since_toggle
                                              : TIME_BITS'(cur.since_toggle + 1'b1);
    ss_inc   = (cur.timed_mode && cur.since_start != TIME_MAX)
               ? TIME_BITS'(cur.since_start + 1'b1) : cur.since_start;

    case (opcode)
      OP_TICK: begin
        if (cur.active) begin
          nxt.since_toggle = st_inc;
          nxt.since_start  = ss_inc;
          // toggle once the interval has run out
          if (CMP_W'(st_inc) >= CMP_W'(cur.period_ms)) begin
            nxt.since_toggle = '0;
            changed          = 1'b1;
            if (cur.lit) begin
              nxt.cur_level = 8'd0;
              nxt.lit       = 1'b0;
              if (counting && cur.blinks_done != CNT16_MAX) begin
                nxt.blinks_done = cur.blinks_done + 16'd1;
              end
            end else begin
              nxt.cur_level = FULL_LEVEL;
              nxt.lit       = 1'b1;
            end
            if (counting && nxt.blinks_done >= cur.target_blinks) begin
              halt = 1'b1;
            end
          end
          if (cur.timed_mode && CMP_W'(ss_inc) >= CMP_W'(cur.total_ms)) begin
            halt = 1'b1;
          end
        end
      end
      OP_ON: begin
        nxt.cur_level = FULL_LEVEL;
        nxt.lit       = 1'b1;
        changed       = 1'b1;
      end
      OP_OFF: begin
        nxt.cur_level = 8'd0;
        nxt.lit       = 1'b0;
        changed       = 1'b1;
      end
      OP_LEVEL: begin
        nxt.cur_level = level;
        nxt.lit       = (level != 8'd0);
        changed       = 1'b1;
      end
      OP_BLINK_N: begin
        nxt.active        = 1'b1;
        nxt.endless_mode  = 1'b0;
        nxt.timed_mode    = 1'b0;
        nxt.target_blinks = times;
        nxt.period_ms     = interval;
        nxt.blinks_done   = '0;
        nxt.since_toggle  = '0;
      end
      OP_BLINK_MS: begin
        nxt.active       = 1'b1;
        nxt.endless_mode = 1'b0;
        nxt.timed_mode   = 1'b1;
        nxt.total_ms     = duration;
        nxt.period_ms    = interval;
        nxt.blinks_done  = '0;
        nxt.since_toggle = '0;
        nxt.since_start  = '0;
      end
      OP_BLINK: begin
        nxt.active       = 1'b1;
        nxt.endless_mode = 1'b1;
        nxt.timed_mode   = 1'b0;
        nxt.period_ms    = interval;
        nxt.since_toggle = '0;
      end
      default: begin
        halt = 1'b1;
      end
    endcase

    // Stop: drop every mode and force the LED dark
    if (halt) begin
      nxt.active       = 1'b0;
      nxt.endless_mode = 1'b0;
      nxt.timed_mode   = 1'b0;
      nxt.cur_level    = 8'd0;
      nxt.lit          = 1'b0;
      changed          = 1'b1;
    end

    res.led_level     = nxt.cur_level;
    res.led_lit       = nxt.lit;
    res.is_blinking   = nxt.active;
    res.state_changed = changed;
    res.blink_ended   = halt;
  end

endmodule

`default_nettype wire

>>> design/led_bs_obuf.sv
// Two-entry result buffer between the update logic and the output stream.
// Depends on led_bs_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module led_bs_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  led_bs_pkg::result_t push_data,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output led_bs_pkg::result_t out_data
);
  import led_bs_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign out_data  = entries[rd_ptr];

  // Hold result beats until the sink takes them
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/led_blink_sequencer_top.sv
// Top level of the LED blink sequencer: sequencer state, update logic and result buffer.
// Depends on led_bs_pkg, led_bs_core and led_bs_obuf.
// Each accepted input beat writes its result beat into the result buffer register.
// Throughput: one beat per cycle; input stays ready while the two-entry result buffer
// has a free slot, so one unread result does not stall the input.
// Reset (rst, synchronous, active high): level 255 with the LED dark, no blink mode,
// all counters zero, result buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // level[7:0], times[23:8], interval[39:24], duration[55:40]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // led_level[7:0], led_lit[8], is_blinking[9],
                                 // state_changed[10], blink_ended[11], zero[15:12]
);
  import led_bs_pkg::*;

  state_t  state;
  state_t  state_next;
  result_t res;
  result_t out_res;
  logic    accept;

  assign accept = s_tvalid & s_tready;

  led_bs_core u_core (
    .cur      (state),
    .opcode   (op_t'(s_tuser)),
    .level    (s_tdata[7:0]),
    .times    (s_tdata[23:8]),
    .interval (s_tdata[39:24]),
    .duration (s_tdata[55:40]),
    .nxt      (state_next),
    .res      (res)
  );

  // Update the sequencer state on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{cur_level: FULL_LEVEL, default: '0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  led_bs_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .has_room  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {4'd0, out_res.blink_ended, out_res.state_changed,
                    out_res.is_blinking, out_res.led_lit, out_res.led_level};

endmodule

`default_nettype wire

>>> design/led_bs_chk.sv
// Port-level checks for the LED blink sequencer, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module led_bs_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [55:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Ready to take a beat straight after reset
  a_ready_after_rst: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // Every taken beat leaves a result waiting on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted beat produced no result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // An ending blink leaves the LED dark and idle
  a_end_dark: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[11]) |->
      (m_tdata[10] && m_tdata[7:0] == 8'd0 && !m_tdata[8] && !m_tdata[9]))
    else $error("blink end without dark idle LED");

  // On every state change the lit flag matches the level
  a_lit_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10]) |-> (m_tdata[8] == (m_tdata[7:0] != 8'd0)))
    else $error("lit flag disagrees with written level");

endmodule

bind led_blink_sequencer_top led_bs_chk u_led_bs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
